[hw/rtl/jcd_pkg.sv]
// Shared types, widths and the per-axis conditioning function for the joystick block.
`default_nettype none

package jcd_pkg;

  localparam int unsigned SAMPLE_W = 11;  // converter reading, top bit flags out of range
  localparam int unsigned VALUE_W  = 10;  // conditioned position and register width
  localparam int unsigned OFFSET_W = 12;  // signed offset, mean minus center
  localparam int unsigned DIFF_W   = 13;  // signed working width of the axis math
  localparam int unsigned BTN_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_DEADZONE = 2'd2
  } cfg_reg_e;

  // Calibration state in force for one axis.
  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]         center;
  } axis_cal_t;

  // Out-of-range sample gives the center; uncalibrated passes the raw code;
  // otherwise remove the offset, snap inside the deadzone, clamp to the code range.
  function automatic logic [VALUE_W-1:0] cond_axis(
    input logic [SAMPLE_W-1:0] sample,
    input axis_cal_t           cal,
    input logic [VALUE_W-1:0]  dz,
    input logic                cal_valid
  );
    logic signed [DIFF_W-1:0] v;
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        mag;
    logic [VALUE_W-1:0]       res;
    v   = $signed({2'b00, sample}) - $signed({cal.offset[OFFSET_W-1], cal.offset});
    d   = v - $signed({3'b000, cal.center});
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    if (sample[SAMPLE_W-1]) begin
      res = cal.center;
    end else if (!cal_valid) begin
      res = sample[VALUE_W-1:0];
    end else if (mag < {3'b000, dz}) begin
      res = cal.center;
    end else if (v[DIFF_W-1]) begin
      res = '0;
    end else if (v[DIFF_W-2:VALUE_W] != '0) begin
      res = VALUE_MAX;
    end else begin
      res = v[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/joystick_calibrate_deadzone.sv]
// Joystick conditioning: offset calibration, deadzone snap and clamp, button decode.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------------
//  in       | in_valid_i / in_stall_o   | func_i, x_sample_i, y_sample_i, button_levels_i
//  out      | out_valid_o / out_stall_i | x_value_o, y_value_o, button_pressed_o,
//           |                           | both_in_range_o, calibrated_o, calibration_done_o
//  cfg      | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; the item is conditioned combinationally
// and lands in the result register on the edge that accepts it.
// The input is stalled only when the result register is full and its item is stalled;
// a result that is being taken frees the register for the next item in the same edge.
// Reset clears the run sums, sample count, offsets and the calibrated flag and
// loads the register defaults; there is no clearing pass.
// The completing calibration item forms its mean with a reciprocal multiply.
`default_nettype none

module joystick_calibrate_deadzone #(
  parameter int unsigned CAL_SAMPLES = 16  // samples per calibration run, 2..256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [jcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [jcd_pkg::VALUE_W-1:0]      cfg_data_i,
  // input items
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             func_i,
  input  wire logic [jcd_pkg::SAMPLE_W-1:0]     x_sample_i,
  input  wire logic [jcd_pkg::SAMPLE_W-1:0]     y_sample_i,
  input  wire logic [jcd_pkg::BTN_W-1:0]        button_levels_i,
  // result items
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [jcd_pkg::VALUE_W-1:0]           x_value_o,
  output logic [jcd_pkg::VALUE_W-1:0]           y_value_o,
  output logic                                  button_pressed_o,
  output logic                                  both_in_range_o,
  output logic                                  calibrated_o,
  output logic                                  calibration_done_o
);
  import jcd_pkg::*;

  // Run sum holds up to CAL_SAMPLES readings of 2047.
  localparam int unsigned CNT_W  = $clog2(CAL_SAMPLES);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  // floor(sum / N) == (sum * RECIP) >> SHIFT for every sum below 2^SUM_W.
  localparam int unsigned SHIFT  = SUM_W + CNT_W;
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RCP_W-1:0] RECIP = RECIP_L[RCP_W-1:0];
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

  // Configuration registers.
  logic [VALUE_W-1:0] center_x_q, center_y_q, deadzone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= VALUE_W'(512);
      center_y_q <= VALUE_W'(512);
      deadzone_q <= VALUE_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        REG_DEADZONE: deadzone_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Handshake: result register frees when empty or drained this edge.
  logic in_acc, out_free;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_acc     = in_valid_i && out_free;

  // Calibration state.
  logic [SUM_W-1:0]           sum_x_q, sum_y_q;
  logic [CNT_W-1:0]           cal_cnt_q;
  logic signed [OFFSET_W-1:0] off_x_q, off_y_q;
  logic                       cal_flag_q;

  logic [SUM_W-1:0]           sum_x_d, sum_y_d;
  logic [PROD_W-1:0]          prod_x, prod_y;
  logic [SAMPLE_W-1:0]        mean_x, mean_y;
  logic signed [OFFSET_W-1:0] off_x_d, off_y_d;
  logic                       cal_last;

  assign sum_x_d  = sum_x_q + SUM_W'(x_sample_i);
  assign sum_y_d  = sum_y_q + SUM_W'(y_sample_i);
  assign prod_x   = PROD_W'(sum_x_d) * PROD_W'(RECIP);
  assign prod_y   = PROD_W'(sum_y_d) * PROD_W'(RECIP);
  assign mean_x   = prod_x[SHIFT +: SAMPLE_W];
  assign mean_y   = prod_y[SHIFT +: SAMPLE_W];
  assign off_x_d  = $signed({1'b0, mean_x}) - $signed({2'b00, center_x_q});
  assign off_y_d  = $signed({1'b0, mean_y}) - $signed({2'b00, center_y_q});
  assign cal_last = func_i && (cal_cnt_q == CNT_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      cal_cnt_q  <= '0;
      off_x_q    <= '0;
      off_y_q    <= '0;
      cal_flag_q <= 1'b0;
    end else if (in_acc && func_i) begin
      if (cal_last) begin
        // run complete: latch offsets, restart accumulation
        off_x_q    <= off_x_d;
        off_y_q    <= off_y_d;
        cal_flag_q <= 1'b1;
        sum_x_q    <= '0;
        sum_y_q    <= '0;
        cal_cnt_q  <= '0;
      end else begin
        sum_x_q   <= sum_x_d;
        sum_y_q   <= sum_y_d;
        cal_cnt_q <= cal_cnt_q + CNT_W'(1);
      end
    end
  end

  // Per-axis conditioning uses the offsets and flag in force before this item.
  axis_cal_t cal_x, cal_y;
  assign cal_x = '{offset: off_x_q, center: center_x_q};
  assign cal_y = '{offset: off_y_q, center: center_y_q};

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_value_o          <= cond_axis(x_sample_i, cal_x, deadzone_q, cal_flag_q);
      y_value_o          <= cond_axis(y_sample_i, cal_y, deadzone_q, cal_flag_q);
      button_pressed_o   <= (button_levels_i == '0);
      both_in_range_o    <= !x_sample_i[SAMPLE_W-1] && !y_sample_i[SAMPLE_W-1];
      calibrated_o       <= cal_flag_q || cal_last;
      calibration_done_o <= cal_last;
    end
  end

  // Checks.
  a_done_implies_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibration_done_o |-> calibrated_o)
    else $error("completing item reported without calibrated flag");

  a_run_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cal_last |=> (cal_cnt_q == '0) && cal_flag_q && (sum_x_q == '0))
    else $error("calibration run did not close");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(cal_flag_q))
    else $error("calibrated flag dropped");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && func_i) |=> $stable(cal_cnt_q) && $stable(off_x_q) && $stable(off_y_q))
    else $error("calibration state moved without a calibration item");

endmodule

`default_nettype wire
